// ===== rtl/core/ert_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ert_pkg
// types and constants shared by the echo request tracker modules
// ----------------------------------------------------------------------------
package ert_pkg;

  // configuration port
  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned REG_OWN_ID = 0;

  // reply checks
  localparam logic [11:0] MIN_ICMP_BYTES  = 12'd8;
  localparam logic [7:0]  ECHO_REPLY_TYPE = 8'd0;

  // input kinds
  localparam logic KIND_SEND  = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  typedef enum logic [2:0] {
    ST_SENT      = 3'd0,
    ST_FULL      = 3'd1,
    ST_MATCHED   = 3'd2,
    ST_SHORT     = 3'd3,
    ST_FOREIGN   = 3'd4,
    ST_UNMATCHED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    OP_SEND   = 2'd0,
    OP_MATCH  = 2'd1,
    OP_REJECT = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    BK_CLEAR = 2'd0,
    BK_IDLE  = 2'd1,
    BK_SCAN  = 2'd2
  } bk_state_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] now_ms;
    logic [3:0]  ip_header_words;
    logic [11:0] packet_length;
    logic [7:0]  msg_type;
    logic [15:0] icmp_id;
    logic [15:0] echo_seq;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] seq_number;
    logic [6:0]  slot_index;
    logic [31:0] round_trip_ms;
    logic [11:0] payload_length;
    logic [15:0] received_total;
  } rsp_t;

  // classified command between front and back
  typedef struct packed {
    op_t         op;
    status_t     rej_status;
    logic [31:0] now_ms;
    logic [15:0] seq;
    logic [11:0] plen;
  } cmd_t;

  // one table slot
  typedef struct packed {
    logic        busy;
    logic [15:0] seq;
    logic [31:0] send_time;
  } entry_t;

endpackage

// ===== rtl/core/ert_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ert_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module ert_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ert_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ert_fifo
// small register queue with push/full and pop/empty handshakes
// ----------------------------------------------------------------------------
module ert_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/ert_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ert_front
// accepts transactions and sorts them into send, match or reject commands
// ----------------------------------------------------------------------------
module ert_front
  import ert_pkg::*;
(
  input  req_t        item,
  input  logic        push,
  output logic        full,
  input  logic [15:0] own_id,
  input  logic        clearing,
  input  logic        cmd_full,
  output logic        cmd_push,
  output cmd_t        cmd_data
);

  logic [11:0] hdr_bytes;
  logic [11:0] plen;
  logic        too_short;
  logic        foreign;

  assign full     = cmd_full || clearing;
  assign cmd_push = push && !full;

  // header length in bytes, payload saturates at zero
  assign hdr_bytes = {6'd0, item.ip_header_words, 2'b00};
  assign plen      = (item.packet_length > hdr_bytes) ?
                     (item.packet_length - hdr_bytes) : 12'd0;
  assign too_short = (plen < MIN_ICMP_BYTES);
  assign foreign   = (item.msg_type != ECHO_REPLY_TYPE) || (item.icmp_id != own_id);

  always_comb begin
    cmd_data.now_ms     = item.now_ms;
    cmd_data.seq        = item.echo_seq;
    cmd_data.plen       = plen;
    cmd_data.op         = OP_MATCH;
    cmd_data.rej_status = ST_UNMATCHED;
    if (item.kind == KIND_SEND) begin
      cmd_data.op   = OP_SEND;
      cmd_data.plen = 12'd0;
    end else if (too_short) begin
      cmd_data.op         = OP_REJECT;
      cmd_data.rej_status = ST_SHORT;
    end else if (foreign) begin
      cmd_data.op         = OP_REJECT;
      cmd_data.rej_status = ST_FOREIGN;
    end
  end

endmodule

// ===== rtl/core/ert_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ert_back
// clears the slot table after reset, then scans it one slot a cycle per send or match command
// ----------------------------------------------------------------------------
module ert_back
  import ert_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 128
) (
  input  logic clk,
  input  logic rst,
  output logic clearing,
  input  cmd_t cmd_data,
  input  logic cmd_empty,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output rsp_t res_data
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = AW + 1;

  bk_state_t   state;
  bk_state_t   state_next;
  logic [CW-1:0] issue_cnt;
  logic [CW-1:0] issue_cnt_next;
  logic        chk_valid;
  logic        chk_valid_next;
  logic [AW-1:0] chk_addr;
  logic [AW-1:0] chk_addr_next;
  logic [15:0] next_seq;
  logic [15:0] next_seq_next;
  logic [15:0] reply_count;
  logic [15:0] reply_count_next;
  cmd_t        cur;

  logic        ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t      ram_wdata;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t      rd_entry;

  logic        take;
  logic        issue_last;
  logic        issue_done;
  logic        chk_last;
  logic        hit;
  logic        miss;
  logic [AW+6:0] slot_ext;

  ert_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (issue_cnt[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_entry   = entry_t'(ram_rdata);
  assign clearing   = (state == BK_CLEAR);
  assign take       = (state == BK_IDLE) && !cmd_empty && !res_full;
  assign issue_last = (issue_cnt[AW-1:0] == AW'(TABLE_ENTRIES - 1));
  assign issue_done = (issue_cnt == CW'(TABLE_ENTRIES));
  assign chk_last   = (chk_addr == AW'(TABLE_ENTRIES - 1));
  assign hit        = chk_valid && ((cur.op == OP_SEND) ? !rd_entry.busy :
                      (rd_entry.busy && (rd_entry.seq == cur.seq)));
  assign miss       = chk_valid && !hit && chk_last;
  assign slot_ext   = {7'd0, chk_addr};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_CLEAR: begin
        if (issue_last) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        if (take && (cmd_data.op != OP_REJECT)) state_next = BK_SCAN;
      end
      BK_SCAN: begin
        if (hit || miss) state_next = BK_IDLE;
      end
      default: state_next = BK_CLEAR;
    endcase
  end

  // datapath and handshakes
  always_comb begin
    cmd_pop          = 1'b0;
    res_push         = 1'b0;
    res_data         = '0;
    res_data.received_total = reply_count;
    ram_we           = 1'b0;
    ram_waddr        = chk_addr;
    ram_wdata        = '0;
    issue_cnt_next   = issue_cnt;
    chk_valid_next   = 1'b0;
    chk_addr_next    = chk_addr;
    next_seq_next    = next_seq;
    reply_count_next = reply_count;
    case (state)
      BK_CLEAR: begin
        ram_we         = 1'b1;
        ram_waddr      = issue_cnt[AW-1:0];
        issue_cnt_next = issue_last ? '0 : issue_cnt + 1'b1;
      end
      BK_IDLE: begin
        issue_cnt_next = '0;
        if (take) begin
          cmd_pop = 1'b1;
          if (cmd_data.op == OP_REJECT) begin
            res_push                = 1'b1;
            res_data.status         = cmd_data.rej_status;
            res_data.payload_length = cmd_data.plen;
          end
        end
      end
      BK_SCAN: begin
        if (!issue_done) begin
          chk_valid_next = 1'b1;
          chk_addr_next  = issue_cnt[AW-1:0];
          issue_cnt_next = issue_cnt + 1'b1;
        end
        if (hit || miss) begin
          chk_valid_next = 1'b0;
          res_push       = 1'b1;
        end
        if (hit) begin
          ram_we = 1'b1;
          res_data.slot_index = slot_ext[6:0];
          if (cur.op == OP_SEND) begin
            ram_wdata.busy      = 1'b1;
            ram_wdata.seq       = next_seq;
            ram_wdata.send_time = cur.now_ms;
            next_seq_next       = next_seq + 1'b1;
            res_data.status     = ST_SENT;
            res_data.seq_number = next_seq;
          end else begin
            ram_wdata.busy          = 1'b0;
            ram_wdata.seq           = rd_entry.seq;
            ram_wdata.send_time     = rd_entry.send_time;
            reply_count_next        = reply_count + 1'b1;
            res_data.status         = ST_MATCHED;
            res_data.seq_number     = cur.seq;
            res_data.round_trip_ms  = cur.now_ms - rd_entry.send_time;
            res_data.payload_length = cur.plen;
            res_data.received_total = reply_count + 1'b1;
          end
        end else if (miss) begin
          if (cur.op == OP_SEND) begin
            res_data.status = ST_FULL;
          end else begin
            res_data.status         = ST_UNMATCHED;
            res_data.payload_length = cur.plen;
          end
        end
      end
      default: begin
        issue_cnt_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_CLEAR;
      issue_cnt   <= '0;
      chk_valid   <= 1'b0;
      next_seq    <= '0;
      reply_count <= '0;
    end else begin
      state       <= state_next;
      issue_cnt   <= issue_cnt_next;
      chk_valid   <= chk_valid_next;
      next_seq    <= next_seq_next;
      reply_count <= reply_count_next;
    end
  end

  always_ff @(posedge clk) begin
    chk_addr <= chk_addr_next;
    if (take) begin
      cur <= cmd_data;
    end
  end

endmodule

// ===== rtl/core/echo_request_tracker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_request_tracker_top
// path: a rejected reply is pushed to the result queue in the same cycle
//   the back takes it, a send or a checked reply only after the table scan
// throughput: one slot per cycle in the table scan; the back takes no new
//   command during a scan, while the command queue can still take items
// reset: a clearing pass frees every slot, full stays high until it ends;
//   own_id resets to 0
// ----------------------------------------------------------------------------
module echo_request_tracker_top
  import ert_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 128
) (
  input  logic              clk,
  input  logic              rst,
  // request side
  input  logic              push,
  output logic              full,
  input  req_t              item,
  // result side
  output logic              empty,
  input  logic              pop,
  output rsp_t              result,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // own id register
  logic [15:0] own_id;
  logic        own_id_sel;

  // front to back command queue
  logic        cmd_push;
  cmd_t        cmd_in;
  logic        cmd_full;
  logic        cmd_pop;
  logic [$bits(cmd_t)-1:0] cmd_out_raw;
  logic        cmd_empty;

  // back to result queue
  logic        res_push;
  rsp_t        res_in;
  logic        res_full;
  logic [$bits(rsp_t)-1:0] res_out_raw;

  logic        clearing;

  // config transaction lands on the access cycle
  assign pready     = 1'b1;
  assign own_id_sel = (paddr[ADDR_W-1:2] == 1'(REG_OWN_ID));
  assign prdata     = own_id_sel ? {16'd0, own_id} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id <= '0;
    end else if (psel && penable && pwrite && pready && own_id_sel) begin
      own_id <= pwdata[15:0];
    end
  end

  // classify incoming transactions
  ert_front u_front (
    .item     (item),
    .push     (push),
    .full     (full),
    .own_id   (own_id),
    .clearing (clearing),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd_data (cmd_in)
  );

  // short queue lets the front keep taking items during a scan
  ert_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_out_raw),
    .empty   (cmd_empty)
  );

  // table scan and update
  ert_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .cmd_data  (cmd_t'(cmd_out_raw)),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_in)
  );

  // result queue, registered output toward the consumer
  ert_fifo #(
    .WIDTH ($bits(rsp_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .pop     (pop),
    .rd_data (res_out_raw),
    .empty   (empty)
  );

  assign result = rsp_t'(res_out_raw);

endmodule
